FILE: src/mpv_pkg.sv
`default_nettype none

package mpv_pkg;

	// field widths
	localparam int REQ_W    = 3;
	localparam int CMD_W    = 24;
	localparam int MIDX_W   = 2;
	localparam int VEL_W    = 16;
	localparam int ANGLE_W  = 13;
	localparam int CUR_W    = 16;
	localparam int DRIVE_W  = 32;
	localparam int POS_W    = 32;
	localparam int ERR_W    = 25;
	localparam int SUM_W    = 36;

	// multiplier operands and product
	localparam int MUL_A_W  = 34;
	localparam int MUL_B_W  = 17;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_THR   = 3'd5;

	localparam logic [7:0]  KP_RST    = 8'd5;
	localparam logic [7:0]  KI_RST    = 8'd5;
	localparam logic [15:0] GAIN_RST  = 16'd6554;
	localparam logic [14:0] LIMIT_RST = 15'd3000;
	localparam logic [14:0] TRIP_RST  = 15'd16000;
	localparam logic [12:0] THR_RST   = 13'd6000;

	// request codes
	localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_VEL    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POS    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SELECT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_ORIGIN = 3'd4;

	// control modes
	localparam logic [1:0] MODE_ZERO = 2'd0;
	localparam logic [1:0] MODE_VEL  = 2'd1;
	localparam logic [1:0] MODE_POS  = 2'd2;

	localparam int MOTOR_COUNT_DEF = 4;

	typedef struct packed {
		logic load;    // capture input beat
		logic decode;  // apply non-tick request, or gain product on a tick
		logic target;  // form target, trip and error
		logic prop;    // first partial sum, proportional product
		logic finish;  // saturate, unwrap, write result
	} mpv_cmd_t;

	typedef struct packed {
		logic is_tick;
	} mpv_stat_t;

endpackage

`default_nettype wire

FILE: src/motor_position_velocity_pi_loop.sv
// A tick passes decode, target, prop and finish to give its result; others give none.
// A new beat waits for a previous tick to reach finish; the single multiplier is shared
// by gain, ki and kp. Command, select and set-origin beats retire in decode.
// Reset (arst_n, asynchronous, active low): gains and limits to defaults, mode zero target,
// motor 0, accumulator, previous error, angles and positions cleared; no clearing pass.
`default_nettype none

module motor_position_velocity_pi_loop
	import mpv_pkg::*;
#(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// request channel
	input  wire logic                     req_valid,
	output logic                          req_stall,
	input  wire logic [REQ_W-1:0]         req_type,
	input  wire logic signed [CMD_W-1:0]  command_value,
	input  wire logic [MIDX_W-1:0]        motor_index,
	input  wire logic signed [VEL_W-1:0]  measured_velocity,
	input  wire logic [ANGLE_W-1:0]       measured_angle,
	input  wire logic signed [CUR_W-1:0]  measured_current,
	// result channel
	output logic                          res_valid,
	input  wire logic                     res_stall,
	output logic [MIDX_W-1:0]             drive_motor,
	output logic signed [DRIVE_W-1:0]     drive_current,
	output logic signed [CMD_W-1:0]       target_velocity,
	output logic signed [POS_W-1:0]       global_position,
	output logic                          tripped,
	// configuration write channel
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

	mpv_cmd_t  cmd;
	mpv_stat_t stat;

	// Config registers live in flops and are always writable; the user must write
	// them only with the loop idle, as the block has no interlock with a running tick.
	assign cfg_ready = 1'b1;

	// Sequencer: idle -> decode -> target -> prop -> finish. Non-tick requests
	// retire in decode. A new beat may be taken in the finish cycle as the
	// result is written to the output register, so back-to-back ticks need no idle
	// state; finish and the new beat both wait while res_stall holds the previous result.
	mpv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid),
		.in_stall  (req_stall),
		.out_valid (res_valid),
		.out_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: one 34x17 multiplier, used in turn for the position gain
	// (decode), ki * previous error (target) and kp * error (prop). The finish
	// cycle sums, saturates to 32 bits and unwraps the encoder angle.
	mpv_dp #(
		.MOTOR_COUNT (MOTOR_COUNT)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.req_type          (req_type),
		.command_value     (command_value),
		.motor_index       (motor_index),
		.measured_velocity (measured_velocity),
		.measured_angle    (measured_angle),
		.measured_current  (measured_current),
		.drive_motor       (drive_motor),
		.drive_current     (drive_current),
		.target_velocity   (target_velocity),
		.global_position   (global_position),
		.tripped           (tripped)
	);

	// A trip always zeroes the target reported with it.
	a_trip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && tripped) |-> (target_velocity == '0))
		else $error("trip reported with non-zero target");

	// Only one beat in flight: the cycle after an accepted beat is stalled.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while previous beat still decoding");

	// Reported motor is always one that exists.
	a_motor_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({2'b00, drive_motor} < (MIDX_W+2)'(MOTOR_COUNT)))
		else $error("drive motor out of range");

endmodule

`default_nettype wire

FILE: src/mpv_ctrl.sv
`default_nettype none

module mpv_ctrl
	import mpv_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire mpv_stat_t stat,
	output mpv_cmd_t       cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_TARGET = 5'b00100,
		ST_PROP   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   accept;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) || ((state_q == ST_FINISH) && slot_free));
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = accept;
		cmd.decode = (state_q == ST_DECODE);
		cmd.target = (state_q == ST_TARGET);
		cmd.prop   = (state_q == ST_PROP);
		cmd.finish = (state_q == ST_FINISH) && slot_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = stat.is_tick ? ST_TARGET : ST_IDLE;
			end
			ST_TARGET: state_d = ST_PROP;
			ST_PROP:   state_d = ST_FINISH;
			ST_FINISH: begin
				if (slot_free) state_d = accept ? ST_DECODE : ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/mpv_dp.sv
`default_nettype none

module mpv_dp
	import mpv_pkg::*;
#(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mpv_cmd_t                 cmd,
	output mpv_stat_t                     stat,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	input  wire logic [REQ_W-1:0]         req_type,
	input  wire logic signed [CMD_W-1:0]  command_value,
	input  wire logic [MIDX_W-1:0]        motor_index,
	input  wire logic signed [VEL_W-1:0]  measured_velocity,
	input  wire logic [ANGLE_W-1:0]       measured_angle,
	input  wire logic signed [CUR_W-1:0]  measured_current,
	output logic [MIDX_W-1:0]             drive_motor,
	output logic signed [DRIVE_W-1:0]     drive_current,
	output logic signed [CMD_W-1:0]       target_velocity,
	output logic signed [POS_W-1:0]       global_position,
	output logic                          tripped
);

	localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam logic [MIDX_W+1:0] MC_CMP = (MIDX_W+2)'(MOTOR_COUNT);

	// configuration
	logic [7:0]  cfg_kp_q, cfg_ki_q;
	logic [15:0] cfg_gain_q;
	logic [14:0] cfg_limit_q, cfg_trip_q;
	logic [12:0] cfg_thr_q;

	// captured beat
	logic [REQ_W-1:0]        req_q;
	logic signed [CMD_W-1:0] cmd_val_q;
	logic [MIDX_W-1:0]       midx_q;
	logic signed [VEL_W-1:0] vel_q;
	logic [ANGLE_W-1:0]      angle_q;
	logic signed [CUR_W-1:0] cur_q;

	// controller state
	logic [1:0]                mode_q;
	logic signed [CMD_W-1:0]   held_q;
	logic [MIDX_W-1:0]         sel_q;
	logic signed [DRIVE_W-1:0] acc_q;
	logic signed [ERR_W-1:0]   prev_q;
	logic [ANGLE_W-1:0]        last_q [MOTOR_COUNT];
	logic signed [POS_W-1:0]   pos_q  [MOTOR_COUNT];

	// working registers
	logic                      perr_neg_q;
	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [CMD_W-1:0]   target_q;
	logic                      trip_q;
	logic signed [SUM_W-1:0]   sum_q;

	// result register
	logic [MIDX_W-1:0]         out_motor_q;
	logic signed [DRIVE_W-1:0] out_drive_q;
	logic signed [CMD_W-1:0]   out_target_q;
	logic signed [POS_W-1:0]   out_pos_q;
	logic                      out_trip_q;

	logic [IDX_W-1:0]          idx;
	logic signed [POS_W-1:0]   pos_cur;
	logic [ANGLE_W-1:0]        last_cur;
	logic signed [POS_W:0]     perr;
	logic [POS_W:0]            pmag;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic [MUL_A_W-1:0]        pq;
	logic [14:0]               mag15;
	logic signed [CMD_W-1:0]   tpos, tbase, tgt;
	logic [CUR_W:0]            cmag;
	logic                      trip_now;
	logic signed [ERR_W-1:0]   err_n;
	logic signed [SUM_W-1:0]   tot;
	logic signed [DRIVE_W-1:0] acc_sat;
	logic signed [ANGLE_W:0]   stp, thr;
	logic signed [ANGLE_W+1:0] stp_adj;
	logic signed [POS_W-1:0]   new_pos;

	assign idx      = IDX_W'(sel_q);
	assign pos_cur  = pos_q[idx];
	assign last_cur = last_q[idx];
	assign stat.is_tick = (req_q == REQ_TICK);

	// position error magnitude for the outer loop
	assign perr = (POS_W+1)'(held_q) - (POS_W+1)'(pos_cur);
	assign pmag = perr[POS_W] ? unsigned'(-perr) : unsigned'(perr);

	// shared multiplier
	always_comb begin
		priority if (cmd.decode) begin
			mul_a = signed'({1'b0, pmag});
			mul_b = signed'({1'b0, cfg_gain_q});
		end else if (cmd.target) begin
			mul_a = MUL_A_W'(prev_q);
			mul_b = signed'({9'd0, cfg_ki_q});
		end else begin
			mul_a = MUL_A_W'(err_q);
			mul_b = signed'({9'd0, cfg_kp_q});
		end
	end
	assign mul_p = mul_a * mul_b;

	// target
	assign pq    = unsigned'(prod_q[MUL_A_W+15:16]);
	assign mag15 = (pq > {19'd0, cfg_limit_q}) ? cfg_limit_q : pq[14:0];
	assign tpos  = perr_neg_q ? -signed'({9'd0, mag15}) : signed'({9'd0, mag15});

	always_comb begin
		unique case (mode_q)
			MODE_VEL: tbase = held_q;
			MODE_POS: tbase = tpos;
			default:  tbase = '0;
		endcase
	end

	assign cmag     = cur_q[CUR_W-1] ? unsigned'(-(CUR_W+1)'(cur_q))
	                                 : unsigned'((CUR_W+1)'(cur_q));
	assign trip_now = cmag > {2'b00, cfg_trip_q};
	assign tgt      = trip_now ? '0 : tbase;
	assign err_n    = ERR_W'(tgt) - ERR_W'(vel_q);

	// accumulate and saturate
	assign tot = sum_q + signed'(prod_q[SUM_W-1:0]);
	always_comb begin
		if (tot[SUM_W-1:DRIVE_W-1] == '0 || tot[SUM_W-1:DRIVE_W-1] == '1) begin
			acc_sat = tot[DRIVE_W-1:0];
		end else if (tot[SUM_W-1]) begin
			acc_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
		end else begin
			acc_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
		end
	end

	// encoder unwrap
	assign stp = signed'({1'b0, angle_q}) - signed'({1'b0, last_cur});
	assign thr = signed'({1'b0, cfg_thr_q});
	always_comb begin
		priority if (stp > thr) begin
			stp_adj = (ANGLE_W+2)'(stp) - 15'sd8192;
		end else if (stp < -thr) begin
			stp_adj = (ANGLE_W+2)'(stp) + 15'sd8192;
		end else begin
			stp_adj = (ANGLE_W+2)'(stp);
		end
	end
	assign new_pos = pos_cur + POS_W'(stp_adj);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_kp_q    <= KP_RST;
			cfg_ki_q    <= KI_RST;
			cfg_gain_q  <= GAIN_RST;
			cfg_limit_q <= LIMIT_RST;
			cfg_trip_q  <= TRIP_RST;
			cfg_thr_q   <= THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KP:    cfg_kp_q    <= cfg_data[7:0];
				CFG_KI:    cfg_ki_q    <= cfg_data[7:0];
				CFG_GAIN:  cfg_gain_q  <= cfg_data;
				CFG_LIMIT: cfg_limit_q <= cfg_data[14:0];
				CFG_TRIP:  cfg_trip_q  <= cfg_data[14:0];
				CFG_THR:   cfg_thr_q   <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ZERO;
			held_q <= '0;
			sel_q  <= '0;
			acc_q  <= '0;
			prev_q <= '0;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				last_q[i] <= '0;
				pos_q[i]  <= '0;
			end
		end else begin
			if (cmd.decode) begin
				unique case (req_q)
					REQ_VEL, REQ_POS: begin
						held_q <= cmd_val_q;
						mode_q <= req_q[1:0];
					end
					REQ_SELECT: begin
						if ({2'b00, midx_q} < MC_CMP) begin
							sel_q  <= midx_q;
							held_q <= '0;
							mode_q <= MODE_VEL;
						end
					end
					REQ_ORIGIN: begin
						pos_q[idx]  <= POS_W'(angle_q);
						last_q[idx] <= angle_q;
					end
					default: ;
				endcase
			end
			if (cmd.target && trip_now) mode_q <= MODE_VEL;
			if (cmd.finish) begin
				acc_q       <= acc_sat;
				prev_q      <= err_q;
				last_q[idx] <= angle_q;
				pos_q[idx]  <= new_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= req_type;
			cmd_val_q <= command_value;
			midx_q    <= motor_index;
			vel_q     <= measured_velocity;
			angle_q   <= measured_angle;
			cur_q     <= measured_current;
		end
		if (cmd.decode || cmd.target || cmd.prop) prod_q <= mul_p;
		if (cmd.decode) perr_neg_q <= perr[POS_W];
		if (cmd.target) begin
			target_q <= tgt;
			trip_q   <= trip_now;
			err_q    <= err_n;
		end
		if (cmd.prop) sum_q <= SUM_W'(acc_q) - signed'(prod_q[SUM_W-1:0]);
		if (cmd.finish) begin
			out_motor_q  <= sel_q;
			out_drive_q  <= acc_sat;
			out_target_q <= target_q;
			out_pos_q    <= new_pos;
			out_trip_q   <= trip_q;
		end
	end

	assign drive_motor     = out_motor_q;
	assign drive_current   = out_drive_q;
	assign target_velocity = out_target_q;
	assign global_position = out_pos_q;
	assign tripped         = out_trip_q;

endmodule

`default_nettype wire

FILE: sim/mpv_drive_checker.sv
module mpv_drive_checker
	import mpv_pkg::*;
#(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    req_valid,
	input  wire logic                    req_stall,
	input  wire logic [REQ_W-1:0]        req_type,
	input  wire logic signed [CMD_W-1:0] command_value,
	input  wire logic [MIDX_W-1:0]       motor_index,
	input  wire logic signed [VEL_W-1:0] measured_velocity,
	input  wire logic [ANGLE_W-1:0]      measured_angle,
	input  wire logic signed [CUR_W-1:0] measured_current,
	input  wire logic                    res_valid,
	input  wire logic                    res_stall,
	input  wire logic [MIDX_W-1:0]       drive_motor,
	input  wire logic signed [DRIVE_W-1:0] drive_current,
	input  wire logic signed [CMD_W-1:0] target_velocity,
	input  wire logic signed [POS_W-1:0] global_position,
	input  wire logic                    tripped,
	input  wire logic                    cfg_valid,
	input  wire logic                    cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	output int                           mismatches,
	output int                           outstanding
);

	localparam longint DRIVE_MAX  = (64'sd1 <<< 31) - 64'sd1;
	localparam longint DRIVE_MIN  = -(64'sd1 <<< 31);
	localparam longint ANGLE_SPAN = 64'sd1 <<< ANGLE_W;
	localparam int     SHOWN_MAX  = 10;

	typedef struct packed {
		logic [MIDX_W-1:0]         motor;
		logic signed [DRIVE_W-1:0] drive;
		logic signed [CMD_W-1:0]   target;
		logic signed [POS_W-1:0]   position;
		logic                      trip;
	} drive_result_t;

	drive_result_t drive_expect_q[$];

	// register copies
	logic [7:0]  kp, ki;
	logic [15:0] pos_gain;
	logic [14:0] vel_limit, trip_level;
	logic [12:0] wrap_thr;

	// controller state
	logic [1:0]                mode;
	logic signed [CMD_W-1:0]   held_cmd;
	logic [MIDX_W-1:0]         sel;
	logic signed [DRIVE_W-1:0] drive_acc;
	logic signed [31:0]        last_err;
	logic [ANGLE_W-1:0]        last_ang [MOTOR_COUNT];
	logic [POS_W-1:0]          upos [MOTOR_COUNT];
	int                        fail_cnt;

	task automatic clear_controller();
		kp         = KP_RST;
		ki         = KI_RST;
		pos_gain   = GAIN_RST;
		vel_limit  = LIMIT_RST;
		trip_level = TRIP_RST;
		wrap_thr   = THR_RST;
		mode       = MODE_ZERO;
		held_cmd   = '0;
		sel        = '0;
		drive_acc  = '0;
		last_err   = '0;
		for (int m = 0; m < MOTOR_COUNT; m++) begin
			last_ang[m] = '0;
			upos[m]     = '0;
		end
		drive_expect_q.delete();
		fail_cnt = 0;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_KP:    kp         = data[7:0];
			CFG_KI:    ki         = data[7:0];
			CFG_GAIN:  pos_gain   = data;
			CFG_LIMIT: vel_limit  = data[14:0];
			CFG_TRIP:  trip_level = data[14:0];
			CFG_THR:   wrap_thr   = data[12:0];
			default:   ;
		endcase
	endtask

	// one control tick: target, trip, incremental PI, angle unwrap
	task automatic run_tick(input logic signed [VEL_W-1:0] vel,
			input logic [ANGLE_W-1:0] ang, input logic signed [CUR_W-1:0] cur);
		longint        tgt, perr, mag, err, sum, step, cur_mag;
		logic          hit;
		drive_result_t r;
		hit = 1'b0;
		case (mode)
			MODE_VEL: tgt = longint'(held_cmd);
			MODE_POS: begin
				perr = longint'(held_cmd) - longint'($signed(upos[sel]));
				mag  = (perr < 0) ? -perr : perr;
				mag  = (mag * longint'(pos_gain)) >> 16;
				if (mag > longint'(vel_limit))
					mag = longint'(vel_limit);
				tgt = (perr < 0) ? -mag : mag;
			end
			default: tgt = 0;
		endcase
		cur_mag = (cur < 0) ? -longint'(cur) : longint'(cur);
		if (cur_mag > longint'(trip_level)) begin
			tgt  = 0;
			mode = MODE_VEL;
			hit  = 1'b1;
		end
		err = tgt - longint'(vel);
		sum = longint'(drive_acc) + longint'(kp) * err - longint'(ki) * longint'(last_err);
		if (sum > DRIVE_MAX)
			sum = DRIVE_MAX;
		if (sum < DRIVE_MIN)
			sum = DRIVE_MIN;
		drive_acc = sum[31:0];
		last_err  = err[31:0];
		step = longint'(ang) - longint'(last_ang[sel]);
		if (step > longint'(wrap_thr))
			step = step - ANGLE_SPAN;
		else if (step < -longint'(wrap_thr))
			step = step + ANGLE_SPAN;
		last_ang[sel] = ang;
		upos[sel]     = upos[sel] + step[31:0];
		r.motor    = sel;
		r.drive    = drive_acc;
		r.target   = tgt[CMD_W-1:0];
		r.position = upos[sel];
		r.trip     = hit;
		drive_expect_q.push_back(r);
	endtask

	task automatic apply_request(input logic [REQ_W-1:0] rt,
			input logic signed [CMD_W-1:0] cmd, input logic [MIDX_W-1:0] midx,
			input logic signed [VEL_W-1:0] vel, input logic [ANGLE_W-1:0] ang,
			input logic signed [CUR_W-1:0] cur);
		case (rt)
			REQ_TICK: run_tick(vel, ang, cur);
			REQ_VEL, REQ_POS: begin
				held_cmd = cmd;
				mode     = (rt == REQ_VEL) ? MODE_VEL : MODE_POS;
			end
			REQ_SELECT: begin
				if (midx < MOTOR_COUNT) begin
					sel      = midx;
					held_cmd = '0;
					mode     = MODE_VEL;
				end
			end
			REQ_ORIGIN: begin
				upos[sel]     = POS_W'(ang);
				last_ang[sel] = ang;
			end
			default: ;
		endcase
	endtask

	task automatic check_result(input drive_result_t got);
		drive_result_t want;
		if (drive_expect_q.size() == 0) begin
			fail_cnt++;
			if (fail_cnt <= SHOWN_MAX)
				$display("unexpected drive beat: motor %0d drive %0d target %0d pos %0d trip %0b",
					got.motor, $signed(got.drive), $signed(got.target),
					$signed(got.position), got.trip);
		end else begin
			want = drive_expect_q.pop_front();
			if (got !== want) begin
				fail_cnt++;
				if (fail_cnt <= SHOWN_MAX)
					$display({"drive mismatch (exp/act): motor %0d/%0d drive %0d/%0d ",
						"target %0d/%0d pos %0d/%0d trip %0b/%0b"},
						want.motor, got.motor, $signed(want.drive), $signed(got.drive),
						$signed(want.target), $signed(got.target),
						$signed(want.position), $signed(got.position), want.trip, got.trip);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_controller();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// results leave before the beat taken at the same edge can produce one
			if (res_valid && !res_stall)
				check_result(drive_result_t'{drive_motor, drive_current, target_velocity,
					global_position, tripped});
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (req_valid && !req_stall)
				apply_request(req_type, command_value, motor_index, measured_velocity,
					measured_angle, measured_current);
			mismatches  <= fail_cnt;
			outstanding <= drive_expect_q.size();
		end
	end

endmodule

FILE: sim/motor_position_velocity_pi_loop_test.sv
module motor_position_velocity_pi_loop_test;
	import mpv_pkg::*;

	// Spare register indexes and request codes the block must ignore.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B      = 3'd7;
	localparam logic [REQ_W-1:0]     REQ_FIRST_UNUSED = 3'd5;

	// Cycles with no beat on any channel before the run is abandoned. The slowest
	// legal gap is a sender gap plus a receiver stall burst plus a tick's pass
	// through decode, target, prop and finish, or the settle pause before a register load.
	localparam int WATCHDOG_LIMIT = 2000;
	// Settle time once the last result is in: non-tick beats may still be in flight.
	localparam int SETTLE_CYCLES  = 8;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// request channel
	logic                    req_valid         = 1'b0;
	logic                    req_stall;
	logic [REQ_W-1:0]        req_type          = REQ_TICK;
	logic signed [CMD_W-1:0] command_value     = '0;
	logic [MIDX_W-1:0]       motor_index       = '0;
	logic signed [VEL_W-1:0] measured_velocity = '0;
	logic [ANGLE_W-1:0]      measured_angle    = '0;
	logic signed [CUR_W-1:0] measured_current  = '0;

	// result channel
	logic                      res_valid;
	logic                      res_stall = 1'b0;
	logic [MIDX_W-1:0]         drive_motor;
	logic signed [DRIVE_W-1:0] drive_current;
	logic signed [CMD_W-1:0]   target_velocity;
	logic signed [POS_W-1:0]   global_position;
	logic                      tripped;

	// configuration channel
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_KP;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int mismatches;
	int outstanding;
	int quiet_cycles = 0;

	// Stimulus bookkeeping: which motor is selected and where its encoder sits,
	// so that ticks can walk the angle rather than jump about.
	bit                 gaps_on   = 1'b1;
	logic [MIDX_W-1:0]  motor_now = '0;
	logic [ANGLE_W-1:0] angle_now [4] = '{default: '0};

	motor_position_velocity_pi_loop i_dut (.*);

	mpv_drive_checker i_checker (.*);

	always #2 clk = ~clk;

	// Receiver side: random stall bursts while gaps are enabled.
	initial begin
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 99) < 20) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Watchdog: counts cycles in which no channel moves a beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (res_valid && !res_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Offer one request beat and hold it until taken. A random sender gap may
	// come first. Valid is left high on return so back-to-back beats never drop
	// it; the caller lowers it when the stream pauses.
	task automatic send_beat(input logic [REQ_W-1:0] rt, input logic [CMD_W-1:0] cmd,
			input logic [MIDX_W-1:0] midx, input logic [VEL_W-1:0] vel,
			input logic [ANGLE_W-1:0] ang, input logic [CUR_W-1:0] cur);
		if (gaps_on && $urandom_range(0, 99) < 25) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_type          <= rt;
		command_value     <= cmd;
		motor_index       <= midx;
		measured_velocity <= vel;
		measured_angle    <= ang;
		measured_current  <= cur;
		req_valid         <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		if (rt == REQ_SELECT)
			motor_now = midx;
		else if (rt == REQ_TICK || rt == REQ_ORIGIN)
			angle_now[motor_now] = ang;
	endtask

	// Stop offering beats, wait for every expected result, then let any
	// non-tick beat still in the pipe settle.
	task automatic quiesce();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Load all six registers, optionally followed by writes to the spare indexes.
	// Only called with the block idle.
	task automatic load_settings(input logic [CFG_DATA_W-1:0] kp_v, ki_v, gain_v,
			lim_v, trip_v, thr_v, input bit spares);
		logic [CFG_IDX_W-1:0]  idx  [8];
		logic [CFG_DATA_W-1:0] vals [8];
		int                    count;
		idx[0] = CFG_KP;      vals[0] = kp_v;
		idx[1] = CFG_KI;      vals[1] = ki_v;
		idx[2] = CFG_GAIN;    vals[2] = gain_v;
		idx[3] = CFG_LIMIT;   vals[3] = lim_v;
		idx[4] = CFG_TRIP;    vals[4] = trip_v;
		idx[5] = CFG_THR;     vals[5] = thr_v;
		idx[6] = CFG_SPARE_A; vals[6] = CFG_DATA_W'($urandom());
		idx[7] = CFG_SPARE_B; vals[7] = CFG_DATA_W'($urandom());
		count = spares ? 8 : 6;
		for (int i = 0; i < count; i++) begin
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			cfg_valid <= 1'b1;
			do
				@(posedge clk);
			while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Random register contents, upper bits beyond each register's width included.
	task automatic load_random_settings();
		load_settings(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
			CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
			CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), 1'b1);
	endtask

	// Mostly well-formed control traffic: ticks with a walking encoder and modest
	// currents, commands near the reachable positions, selects and origins. A
	// share of full-range values and unused request codes is mixed in.
	task automatic random_beats(input int count);
		int                 n;
		int                 kind;
		logic [REQ_W-1:0]   rt;
		logic [CMD_W-1:0]   cmd;
		logic [VEL_W-1:0]   vel;
		logic [ANGLE_W-1:0] ang;
		logic [CUR_W-1:0]   cur;
		n = 0;
		while (n < count) begin
			kind = $urandom_range(0, 99);
			// unused fields carry noise
			cmd = CMD_W'($urandom());
			vel = VEL_W'($urandom());
			ang = ANGLE_W'($urandom());
			cur = CUR_W'($urandom());
			n++;
			if (kind < 58) begin
				rt = REQ_TICK;
				case ($urandom_range(0, 9))
					0: ;  // full-range angle jump
					1, 2: ang = angle_now[motor_now] + ANGLE_W'($urandom_range(0, 6000))
						- ANGLE_W'(3000);
					default: ang = angle_now[motor_now] + ANGLE_W'($urandom_range(0, 400))
						- ANGLE_W'(200);
				endcase
				if ($urandom_range(0, 3) != 0)
					vel = VEL_W'($urandom_range(0, 4000)) - VEL_W'(2000);
				if ($urandom_range(0, 5) != 0)
					cur = CUR_W'($urandom_range(0, 20000)) - CUR_W'(10000);
			end else if (kind < 68) begin
				rt = REQ_VEL;
				if ($urandom_range(0, 3) != 0)
					cmd = CMD_W'($urandom_range(0, 6000)) - CMD_W'(3000);
			end else if (kind < 78) begin
				rt = REQ_POS;
				if ($urandom_range(0, 3) != 0)
					cmd = CMD_W'($urandom_range(0, 40000)) - CMD_W'(20000);
			end else if (kind < 88) begin
				rt = REQ_SELECT;
			end else if (kind < 96) begin
				rt = REQ_ORIGIN;
			end else begin
				// ignored by the block, so not counted
				rt = REQ_FIRST_UNUSED + REQ_W'($urandom_range(0, 2));
				n--;
			end
			send_beat(rt, cmd, MIDX_W'($urandom()), vel, ang, cur);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats at reset settings.
		// zero-target mode, all fields at zero
		send_beat(REQ_TICK, '0, '0, '0, '0, '0);
		// overcurrent at the positive extreme, downward wrap from 0 to 8191
		send_beat(REQ_TICK, '0, '0, 16'h8000, 13'h1FFF, 16'h7FFF);
		send_beat(REQ_VEL, 24'h7FFFFF, '0, '0, '0, '0);
		// trip on the most negative current keeps the held command
		send_beat(REQ_TICK, '0, '0, 16'h7FFF, 13'h1FFF, 16'h8000);
		// current equal to the trip level does not trip
		send_beat(REQ_TICK, '0, '0, 16'h7FFF, 13'd1000, 16'd16000);
		send_beat(REQ_VEL, 24'h800000, '0, '0, '0, '0);
		// step equal to the wrap threshold is taken as a real move
		send_beat(REQ_TICK, '0, '0, 16'h8000, 13'd7000, -16'sd16000);
		// one past the threshold downwards wraps up; current one above trips
		send_beat(REQ_TICK, '0, '0, '0, 13'd999, 16'd16001);
		// position mode clamped at both ends
		send_beat(REQ_POS, 24'h7FFFFF, '0, '0, '0, '0);
		send_beat(REQ_TICK, '0, '0, '0, 13'd999, '0);
		send_beat(REQ_POS, 24'h800000, '0, '0, '0, '0);
		send_beat(REQ_TICK, '0, '0, '0, 13'd999, '0);
		// negative error: the gain product truncates toward zero
		send_beat(REQ_POS, -24'sd7, '0, '0, '0, '0);
		send_beat(REQ_TICK, '0, '0, 16'd5, 13'd999, '0);
		// other motors keep their own angle history; origin latch
		send_beat(REQ_SELECT, 24'h123456, 2'd3, '0, '0, '0);
		send_beat(REQ_TICK, '0, '0, '0, 13'd4000, '0);
		send_beat(REQ_ORIGIN, '0, '0, '0, 13'd100, '0);
		send_beat(REQ_TICK, '0, '0, '0, 13'd200, '0);
		send_beat(REQ_SELECT, '0, 2'd1, '0, '0, '0);
		send_beat(REQ_TICK, '0, '0, 16'd300, 13'd8000, '0);
		send_beat(REQ_SELECT, '0, 2'd2, '0, '0, '0);
		send_beat(REQ_TICK, '0, '0, -16'sd300, 13'd50, '0);
		// unused request codes change nothing
		send_beat(REQ_FIRST_UNUSED, 24'h7FFFFF, 2'd3, '1, '1, '1);
		send_beat(REQ_FIRST_UNUSED + 3'd1, 24'h7FFFFF, 2'd3, '1, '1, '1);
		send_beat(REQ_FIRST_UNUSED + 3'd2, 24'h7FFFFF, 2'd3, '1, '1, '1);
		send_beat(REQ_SELECT, '0, 2'd0, '0, '0, '0);
		send_beat(REQ_TICK, '0, '0, '0, 13'd999, '0);
		quiesce();

		// Accumulator saturation both ways: top kp and position gain, ki at zero, widest limits.
		load_settings(16'd255, 16'd0, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h1FFF, 1'b0);
		send_beat(REQ_VEL, 24'h7FFFFF, '0, '0, '0, '0);
		repeat (3) send_beat(REQ_TICK, '0, '0, 16'h8000, angle_now[motor_now], '0);
		send_beat(REQ_VEL, 24'h800000, '0, '0, '0, '0);
		repeat (3) send_beat(REQ_TICK, '0, '0, 16'h7FFF, angle_now[motor_now], '0);
		quiesce();

		// Reset values restored, spare indexes poked.
		load_settings(16'hFF05, 16'h0005, 16'd6554, 16'd3000, 16'd16000, 16'd6000, 1'b1);
		random_beats(80);
		quiesce();

		// Everything at its maximum.
		load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		random_beats(70);
		quiesce();

		// Everything at zero: every non-zero current trips, every non-zero step wraps.
		load_settings('0, '0, '0, '0, '0, '0, 1'b0);
		random_beats(60);
		quiesce();

		// Random settings, no idling on either side.
		gaps_on = 1'b0;
		load_random_settings();
		random_beats(70);
		quiesce();

		gaps_on = 1'b1;
		load_random_settings();
		random_beats(70);
		quiesce();

		// Closing stretch at full rate.
		gaps_on = 1'b0;
		load_random_settings();
		random_beats(50);
		quiesce();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
